>>> sv/wpp_pkg.sv
// Shared types and constants for the WAV PCM16 stream parser.
`default_nettype none

package wpp_pkg;

  // Chunk tags as they gather little-endian into a 32-bit word
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Format checks
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] DEPTH_16  = 16'd16;
  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  // End status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_NO_FORMAT = 3'd3;
  localparam logic [2:0] ST_NO_DATA   = 3'd4;
  localparam logic [2:0] ST_NOT_PCM   = 3'd5;
  localparam logic [2:0] ST_NOT_16BIT = 3'd6;

  // Result kinds on out_tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Queue between parser and result stage
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queue entry: the results one byte causes
  typedef struct packed {
    logic        has_smp;
    logic        has_sts;
    logic [15:0] smp;
    logic [2:0]  sts;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [30:0] total;
  } wpp_entry_t;

endpackage

`default_nettype wire

>>> sv/wpp_front.sv
// Byte parser: walks RIFF/WAVE chunks and queues sample and status results.
`default_nettype none

module wpp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_beat,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  output logic                    push,
  output wpp_pkg::wpp_entry_t     push_data
);
  import wpp_pkg::*;

  typedef enum logic [9:0] {
    PH_RIFF  = 10'b00_0000_0001,
    PH_FSIZE = 10'b00_0000_0010,
    PH_WAVE  = 10'b00_0000_0100,
    PH_CID   = 10'b00_0000_1000,
    PH_CSIZE = 10'b00_0001_0000,
    PH_FMT   = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_SKIP  = 10'b00_1000_0000,
    PH_PAD   = 10'b01_0000_0000,
    PH_DONE  = 10'b10_0000_0000
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [3:0]  idx_r,       idx_nxt;
  logic [31:0] gather_r,    gather_nxt;
  logic [31:0] tag_r,       tag_nxt;
  logic [31:0] left_r,      left_nxt;
  logic        pad_r,       pad_nxt;
  logic        fmt_seen_r,  fmt_seen_nxt;
  logic        data_seen_r, data_seen_nxt;
  logic [15:0] fmt_code_r,  fmt_code_nxt;
  logic [15:0] chans_r,     chans_nxt;
  logic [31:0] rate_r,      rate_nxt;
  logic [15:0] depth_r,     depth_nxt;
  logic [7:0]  low_r,       low_nxt;
  logic [30:0] count_r,     count_nxt;
  logic [2:0]  err_r,       err_nxt;

  logic [31:0] gather_shift;
  logic [31:0] left_dec;
  logic        smp_ok;
  logic [15:0] smp_val;
  logic [2:0]  sts_val;

  // Per-byte state update
  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    gather_nxt    = gather_r;
    tag_nxt       = tag_r;
    left_nxt      = left_r;
    pad_nxt       = pad_r;
    fmt_seen_nxt  = fmt_seen_r;
    data_seen_nxt = data_seen_r;
    fmt_code_nxt  = fmt_code_r;
    chans_nxt     = chans_r;
    rate_nxt      = rate_r;
    depth_nxt     = depth_r;
    low_nxt       = low_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    smp_ok        = 1'b0;
    smp_val       = '0;
    gather_shift  = {in_byte, gather_r[31:8]};
    left_dec      = left_r - 32'd1;

    case (phase_r)
      PH_RIFF, PH_FSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
        gather_nxt = gather_shift;
        idx_nxt    = idx_r + 4'd1;
        if (idx_r == 4'd3) begin
          idx_nxt = 4'd0;
          case (phase_r)
            PH_RIFF: begin
              if (gather_shift != TAG_RIFF) begin
                err_nxt   = ST_NOT_RIFF;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_FSIZE;
              end
            end
            PH_FSIZE: phase_nxt = PH_WAVE;
            PH_WAVE: begin
              if (gather_shift != TAG_WAVE) begin
                err_nxt   = ST_NOT_WAVE;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_CID;
              end
            end
            PH_CID: begin
              tag_nxt   = gather_shift;
              phase_nxt = PH_CSIZE;
            end
            default: begin
              // Chunk size complete: open the chunk body
              left_nxt = gather_shift;
              pad_nxt  = gather_shift[0];
              if (tag_r == TAG_DATA && !data_seen_r && !fmt_seen_r) begin
                err_nxt   = ST_NO_FORMAT;
                phase_nxt = PH_DONE;
              end else begin
                if (tag_r == TAG_FMT) begin
                  fmt_seen_nxt = 1'b1;
                  fmt_code_nxt = '0;
                  chans_nxt    = '0;
                  rate_nxt     = '0;
                  depth_nxt    = '0;
                  phase_nxt    = PH_FMT;
                end else if (tag_r == TAG_DATA && !data_seen_r) begin
                  data_seen_nxt = 1'b1;
                  phase_nxt     = PH_DATA;
                end else begin
                  phase_nxt = PH_SKIP;
                end
                // Empty body: size even, so straight to the next tag
                if (gather_shift == 32'd0) begin
                  phase_nxt = PH_CID;
                end
              end
            end
          endcase
        end
      end

      PH_FMT: begin
        case (idx_r)
          4'd0:  fmt_code_nxt[7:0]  = in_byte;
          4'd1:  fmt_code_nxt[15:8] = in_byte;
          4'd2:  chans_nxt[7:0]     = in_byte;
          4'd3:  chans_nxt[15:8]    = in_byte;
          4'd4:  rate_nxt[7:0]      = in_byte;
          4'd5:  rate_nxt[15:8]     = in_byte;
          4'd6:  rate_nxt[23:16]    = in_byte;
          4'd7:  rate_nxt[31:24]    = in_byte;
          4'd14: depth_nxt[7:0]     = in_byte;
          4'd15: depth_nxt[15:8]    = in_byte;
          default: ;
        endcase
        idx_nxt  = idx_r + 4'd1;
        left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          phase_nxt = pad_r ? PH_PAD : PH_CID;
          idx_nxt   = 4'd0;
        end else if (idx_r == 4'd15) begin
          phase_nxt = PH_SKIP;
        end
      end

      PH_DATA: begin
        if (!idx_r[0]) begin
          low_nxt = in_byte;
        end else if (fmt_code_r == FMT_PCM && depth_r == DEPTH_16) begin
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 31'd1;
          end
          smp_ok  = 1'b1;
          smp_val = {in_byte, low_r};
        end
        idx_nxt  = idx_r ^ 4'd1;
        left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          phase_nxt = pad_r ? PH_PAD : PH_CID;
          idx_nxt   = 4'd0;
        end
      end

      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          phase_nxt = pad_r ? PH_PAD : PH_CID;
          idx_nxt   = 4'd0;
        end
      end

      PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_nxt = PH_CID;
        idx_nxt   = 4'd0;
      end

      default: ;
    endcase

    // End status, from the state this byte leaves
    if (err_nxt != ST_OK) begin
      sts_val = err_nxt;
    end else if (phase_nxt == PH_RIFF) begin
      sts_val = ST_NOT_RIFF;
    end else if (phase_nxt == PH_FSIZE || phase_nxt == PH_WAVE) begin
      sts_val = ST_NOT_WAVE;
    end else if (!fmt_seen_nxt) begin
      sts_val = ST_NO_FORMAT;
    end else if (!data_seen_nxt) begin
      sts_val = ST_NO_DATA;
    end else if (fmt_code_nxt != FMT_PCM) begin
      sts_val = ST_NOT_PCM;
    end else if (depth_nxt != DEPTH_16) begin
      sts_val = ST_NOT_16BIT;
    end else begin
      sts_val = ST_OK;
    end
  end

  // Queue entry for this byte
  always_comb begin
    push              = in_beat && (smp_ok || in_last);
    push_data.has_smp = smp_ok;
    push_data.has_sts = in_last;
    push_data.smp     = smp_val;
    push_data.sts     = sts_val;
    push_data.rate    = rate_nxt;
    push_data.chans   = chans_nxt;
    push_data.total   = count_nxt;
  end

  // Parser state; the last byte of a file returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (in_beat && in_last)) begin
      phase_r     <= PH_RIFF;
      idx_r       <= '0;
      gather_r    <= '0;
      tag_r       <= '0;
      left_r      <= '0;
      pad_r       <= 1'b0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      fmt_code_r  <= '0;
      chans_r     <= '0;
      rate_r      <= '0;
      depth_r     <= '0;
      low_r       <= '0;
      count_r     <= '0;
      err_r       <= ST_OK;
    end else if (in_beat) begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      gather_r    <= gather_nxt;
      tag_r       <= tag_nxt;
      left_r      <= left_nxt;
      pad_r       <= pad_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      data_seen_r <= data_seen_nxt;
      fmt_code_r  <= fmt_code_nxt;
      chans_r     <= chans_nxt;
      rate_r      <= rate_nxt;
      depth_r     <= depth_nxt;
      low_r       <= low_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
    end
  end

  // A new file starts right after the last beat
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_last |=> phase_r == PH_RIFF && count_r == '0)
    else $error("parser did not restart after last beat");

  // Samples only come out of a data chunk body
  a_smp_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    smp_ok |-> phase_r == PH_DATA && idx_r[0])
    else $error("sample outside data chunk");

endmodule

`default_nettype wire

>>> sv/wpp_fifo.sv
// Short result queue between the parser and the output stage.
`default_nettype none

module wpp_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire wpp_pkg::wpp_entry_t push_data,
  input  wire logic                pop,
  output wpp_pkg::wpp_entry_t      head,
  output logic                     full,
  output logic                     empty
);
  import wpp_pkg::*;

  wpp_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r,    cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> sv/wpp_back.sv
// Output stage: splits queue entries into sample and status beats.
`default_nettype none

module wpp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wpp_pkg::wpp_entry_t head,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [15:0]              out_smp,
  output logic [2:0]               out_sts,
  output logic [31:0]              out_rate,
  output logic [15:0]              out_chans,
  output logic [30:0]              out_total
);
  import wpp_pkg::*;

  logic        valid_r, valid_nxt;
  logic        sent_r,  sent_nxt;
  logic        load;
  logic        take_smp;
  logic        kind_r;
  logic [15:0] smp_r;
  logic [2:0]  sts_r;
  logic [31:0] rate_r;
  logic [15:0] chans_r;
  logic [30:0] total_r;

  // Pick the next result from the queue head
  always_comb begin
    load      = !empty && (!valid_r || out_ready);
    take_smp  = head.has_smp && !sent_r;
    pop       = 1'b0;
    sent_nxt  = sent_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
      if (take_smp && head.has_sts) begin
        sent_nxt = 1'b1;
      end else begin
        sent_nxt = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sent_r  <= sent_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= take_smp ? KIND_SAMPLE : KIND_STATUS;
      smp_r   <= take_smp ? head.smp : 16'd0;
      sts_r   <= take_smp ? ST_OK : head.sts;
      rate_r  <= head.rate;
      chans_r <= head.chans;
      total_r <= head.total;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_smp   = smp_r;
  assign out_sts   = sts_r;
  assign out_rate  = rate_r;
  assign out_chans = chans_r;
  assign out_total = total_r;

  a_smp_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_SAMPLE |-> sts_r == ST_OK)
    else $error("sample beat carries a status");

  a_sts_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_STATUS |-> smp_r == 16'd0)
    else $error("status beat carries a sample");

  a_split_pops: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> !empty && head.has_sts)
    else $error("half-sent entry lost");

endmodule

`default_nettype wire

>>> sv/wav_pcm16_stream_parser_top.sv
// Top level of the WAV PCM16 stream parser.
//
//  channel | dir | beat payload
//  --------+-----+----------------------------------------------------------
//  in_     | in  | tdata[7:0] file byte, tlast = last byte of the file
//  out_    | out | tuser = kind (0 sample, 1 end status), tdata = fields below
//
// One byte is taken per cycle while in_tready is high; results are registered.
// The parser updates all chunk state in the cycle a byte arrives.
// A four-entry queue separates parser and output; in_tready drops only when
// the queue is full, e.g. after long out_tready stalls. A last byte that also
// completes a sample uses two output beats. rst_n is synchronous; no warm-up.
`default_nettype none

module wav_pcm16_stream_parser_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,   // end_of_file
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // [15:0] sample_q15, [18:16] status,
                                        // [50:19] rate_hz, [66:51] channel_count,
                                        // [97:67] sample_total, rest zero
  output logic              out_tuser   // [0] kind
);
  import wpp_pkg::*;

  wpp_entry_t  push_data;
  wpp_entry_t  head;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic        in_beat;
  logic [15:0] smp;
  logic [2:0]  sts;
  logic [31:0] rate;
  logic [15:0] chans;
  logic [30:0] total;

  assign in_tready = !full;
  assign in_beat   = in_tvalid && in_tready;

  wpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .push_data (push_data)
  );

  wpp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  wpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_smp   (smp),
    .out_sts   (sts),
    .out_rate  (rate),
    .out_chans (chans),
    .out_total (total)
  );

  // Pack result fields, first field lowest
  assign out_tdata = {6'd0, total, chans, rate, sts, smp};

endmodule

`default_nettype wire

>>> test/tb_wav_pcm16_stream_parser_top.sv
// Testbench for the WAV PCM16 stream parser: directed rows, then random files, checked per beat.
module tb_wav_pcm16_stream_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wpp_pkg::*;

  // Parse position inside the file
  typedef enum logic [3:0] {
    P_RIFF, P_FSIZE, P_WAVE, P_CID, P_CSIZE, P_FMT, P_DATA, P_SKIP, P_PAD, P_DONE
  } parse_stage_t;

  // One output beat as the parser should produce it
  typedef struct {
    logic        kind;
    logic [15:0] smp;
    logic [2:0]  sts;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [30:0] total;
  } wav_beat_t;

  // One directed stimulus row; pin forces the end status to the typed value
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         pin;
    logic [2:0] sts;
  } byte_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tuser;

  wav_beat_t  owed_beats[$];
  logic [7:0] file_bytes[$];
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  bit         idle_on = 1'b1;
  bit         hold_request = 1'b0;

  // Parser state mirrored by the predictor
  parse_stage_t stage;
  logic [3:0]   idx;
  logic [31:0]  shift_word, tag_word, remain, rate;
  logic         pad_due, fmt_seen, data_taken;
  logic [15:0]  fmt_code, chans, depth;
  logic [7:0]   lo_byte;
  logic [30:0]  smp_count;
  logic [2:0]   err_code;

  // Short files: end inside the RIFF tag, bad RIFF tag, end in size, bad WAVE tag
  byte_row_t dir_rows[22] = '{
    '{8'h00, 1'b1, 1'b1, ST_NOT_RIFF},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_NOT_RIFF},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK}, '{8'h46, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_NOT_WAVE},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK}, '{8'h46, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h57, 1'b0, 1'b0, ST_OK},
    '{8'h41, 1'b0, 1'b0, ST_OK}, '{8'h56, 1'b0, 1'b0, ST_OK}, '{8'hC5, 1'b1, 1'b1, ST_NOT_WAVE}
  };

  wav_pcm16_stream_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic clear_parser();
    stage      = P_RIFF;
    idx        = '0;
    shift_word = '0;
    tag_word   = '0;
    remain     = '0;
    pad_due    = 1'b0;
    fmt_seen   = 1'b0;
    data_taken = 1'b0;
    fmt_code   = '0;
    chans      = '0;
    rate       = '0;
    depth      = '0;
    lo_byte    = '0;
    smp_count  = '0;
    err_code   = ST_OK;
  endtask

  // Advance the parser by one byte and queue the beats it causes
  task automatic parse_byte(input logic [7:0] b, input logic last, input bit pin,
                            input logic [2:0] pin_sts);
    wav_beat_t beat;
    bit        chunk_done;
    chunk_done = 1'b0;
    case (stage)
      P_RIFF, P_FSIZE, P_WAVE, P_CID, P_CSIZE: begin
        shift_word = {b, shift_word[31:8]};
        idx = idx + 4'd1;
        if (idx == 4'd4) begin
          idx = '0;
          case (stage)
            P_RIFF: begin
              if (shift_word != TAG_RIFF) begin
                err_code = ST_NOT_RIFF;
                stage = P_DONE;
              end else stage = P_FSIZE;
            end
            P_FSIZE: stage = P_WAVE;
            P_WAVE: begin
              if (shift_word != TAG_WAVE) begin
                err_code = ST_NOT_WAVE;
                stage = P_DONE;
              end else stage = P_CID;
            end
            P_CID: begin
              tag_word = shift_word;
              stage = P_CSIZE;
            end
            default: begin
              // size known: decide how the body is treated
              remain = shift_word;
              pad_due = shift_word[0];
              if (tag_word == TAG_FMT) begin
                fmt_seen = 1'b1;
                fmt_code = '0;
                chans = '0;
                rate = '0;
                depth = '0;
                stage = P_FMT;
              end else if (tag_word == TAG_DATA && !data_taken && !fmt_seen) begin
                err_code = ST_NO_FORMAT;
                stage = P_DONE;
              end else if (tag_word == TAG_DATA && !data_taken) begin
                data_taken = 1'b1;
                stage = P_DATA;
              end else stage = P_SKIP;
              chunk_done = (stage != P_DONE) && (remain == 0);
            end
          endcase
        end
      end
      P_FMT: begin
        case (idx)
          4'd0: fmt_code[7:0] = b;
          4'd1: fmt_code[15:8] = b;
          4'd2: chans[7:0] = b;
          4'd3: chans[15:8] = b;
          4'd4, 4'd5, 4'd6, 4'd7: rate[{idx[1:0], 3'b000} +: 8] = b;
          4'd14: depth[7:0] = b;
          4'd15: depth[15:8] = b;
          default: ;
        endcase
        idx = idx + 4'd1;
        remain = remain - 1;
        // past 16 bytes the rest of the fmt body is skipped
        if (remain == 0) chunk_done = 1'b1;
        else if (idx == 4'd0) stage = P_SKIP;
      end
      P_DATA: begin
        if (!idx[0]) lo_byte = b;
        else if (fmt_code == FMT_PCM && depth == DEPTH_16) begin
          if (smp_count != COUNT_MAX) smp_count = smp_count + 1;
          beat = '{KIND_SAMPLE, {b, lo_byte}, ST_OK, rate, chans, smp_count};
          owed_beats.push_back(beat);
        end
        idx[0] = ~idx[0];
        remain = remain - 1;
        chunk_done = (remain == 0);
      end
      P_SKIP: begin
        remain = remain - 1;
        chunk_done = (remain == 0);
      end
      P_PAD: begin
        pad_due = 1'b0;
        stage = P_CID;
        idx = '0;
      end
      default: ;
    endcase
    // body finished: pad byte or next chunk header follows
    if (chunk_done) begin
      stage = pad_due ? P_PAD : P_CID;
      idx = '0;
    end
    // end of file: status from what was seen, then a fresh file
    if (last) begin
      beat = '{KIND_STATUS, 16'h0000, ST_OK, rate, chans, smp_count};
      if (pin) beat.sts = pin_sts;
      else if (err_code != ST_OK) beat.sts = err_code;
      else if (stage == P_RIFF) beat.sts = ST_NOT_RIFF;
      else if (stage == P_FSIZE || stage == P_WAVE) beat.sts = ST_NOT_WAVE;
      else if (!fmt_seen) beat.sts = ST_NO_FORMAT;
      else if (!data_taken) beat.sts = ST_NO_DATA;
      else if (fmt_code != FMT_PCM) beat.sts = ST_NOT_PCM;
      else if (depth != DEPTH_16) beat.sts = ST_NOT_16BIT;
      owed_beats.push_back(beat);
      clear_parser();
    end
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
  endtask

  // Build one file into file_bytes; tidy gives a clean PCM16 file with a long data chunk
  task automatic make_wav(input bit tidy);
    int          mode, n_chunks, pick, sz, cut;
    logic [15:0] code_v, chans_v, depth_v;
    logic [7:0]  fmt_body[16];
    logic [7:0]  rim_vals[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    file_bytes.delete();
    mode = tidy ? 0 : $urandom_range(0, 15);
    // plain noise
    if (mode == 15) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom()));
      return;
    end
    put_word(TAG_RIFF);
    put_word($urandom());
    put_word(TAG_WAVE);
    // broken header: one flipped bit in the tags or the file size
    if (mode == 14) begin
      sz = $urandom_range(0, 11);
      file_bytes[sz] = file_bytes[sz] ^ (8'h01 << $urandom_range(0, 7));
    end
    n_chunks = tidy ? 2 : $urandom_range(0, 5);
    for (int c = 0; c < n_chunks; c++) begin
      // 0 fmt, 1..5 data, 6..8 other, 9 open-ended body cut by the end of file
      if (tidy) pick = (c == 0) ? 0 : 1;
      else if (c == 0) pick = ($urandom_range(0, 7) != 0) ? 0 : $urandom_range(1, 9);
      else pick = $urandom_range(0, 9);
      if (pick == 0) begin
        code_v  = (tidy || $urandom_range(0, 3) != 0) ? FMT_PCM : 16'($urandom());
        chans_v = $urandom_range(0, 1) ? 16'($urandom_range(1, 2)) : 16'($urandom());
        depth_v = (tidy || $urandom_range(0, 3) != 0) ? DEPTH_16 : 16'($urandom_range(0, 32));
        for (int k = 0; k < 16; k++) fmt_body[k] = 8'($urandom());
        {fmt_body[1], fmt_body[0]} = code_v;
        {fmt_body[3], fmt_body[2]} = chans_v;
        {fmt_body[7], fmt_body[6], fmt_body[5], fmt_body[4]} = $urandom();
        {fmt_body[15], fmt_body[14]} = depth_v;
        case ($urandom_range(0, 7))
          5: sz = 18;
          6: sz = $urandom_range(0, 15);
          7: sz = 17;
          default: sz = 16;
        endcase
        if (tidy) sz = 16;
        put_word(TAG_FMT);
        put_word(sz);
        for (int k = 0; k < sz; k++)
          file_bytes.push_back(k < 16 ? fmt_body[k] : 8'($urandom()));
      end else if (pick <= 5) begin
        sz = tidy ? $urandom_range(40, 80) : $urandom_range(0, 40);
        put_word(TAG_DATA);
        put_word(sz);
        for (int k = 0; k < sz; k++)
          file_bytes.push_back($urandom_range(0, 3) == 0 ? rim_vals[$urandom_range(0, 3)]
                                                         : 8'($urandom()));
      end else if (pick <= 8) begin
        sz = $urandom_range(0, 9);
        put_word($urandom());
        put_word(sz);
        repeat (sz) file_bytes.push_back(8'($urandom()));
      end else begin
        put_word($urandom_range(0, 1) ? TAG_DATA : 32'($urandom()));
        put_word({24'hFF_FFFF, 8'($urandom())});
        repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom()));
        break;
      end
      if (sz % 2 != 0) file_bytes.push_back(8'($urandom()));
    end
    // truncated file
    if (!tidy && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  // Offer one beat at the falling edge and wait for the handshake
  task automatic send_byte(input logic [7:0] b, input logic last, input bit pin,
                           input logic [2:0] pin_sts);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    parse_byte(b, last, pin, pin_sts);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int file_no;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].pin, dir_rows[i].sts);
    file_no = 0;
    while (bytes_sent < 1200) begin
      if (bytes_sent >= 950) idle_on = 1'b0;
      // long output stall over a clean file so the input backs up
      if (file_no == 1 || file_no == 10) begin
        hold_request = 1'b1;
        make_wav(1'b1);
      end else make_wav(1'b0);
      // sender pause until every queued beat has drained
      if (file_no == 5 || file_no == 13) begin
        in_tvalid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      foreach (file_bytes[i])
        send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, ST_OK);
      file_no++;
    end
    in_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus long holds on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Compare each output beat with the oldest owed one
  always @(posedge clk) begin
    wav_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_beats.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: beat expected none, got tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = owed_beats.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("sample_q15", want.smp, out_tdata[15:0]);
        check_field("status", want.sts, out_tdata[18:16]);
        check_field("rate_hz", want.rate, out_tdata[50:19]);
        check_field("channel_count", want.chans, out_tdata[66:51]);
        check_field("sample_total", want.total, out_tdata[97:67]);
        check_field("tdata pad", 32'd0, out_tdata[103:98]);
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
